// ----- rtl/bitplane_to_chunky_row_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the bitplane to chunky row converter
// Same-cycle-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef BITPLANE_TO_CHUNKY_ROW_ASSERT_SVH
`define BITPLANE_TO_CHUNKY_ROW_ASSERT_SVH

// same-cycle implication, masked during reset
`define BPCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitplane_to_chunky_row: assertion failed");

// next-cycle implication, masked during reset
`define BPCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitplane_to_chunky_row: assertion failed");

`endif

// ----- rtl/bpcr_pkg.sv -----
// ---------------------------------------------------------------------------
// bpcr_pkg
// Shared constants and types of the bitplane to chunky row converter.
// ---------------------------------------------------------------------------
package bpcr_pkg;

  // default row capacity in pixels
  localparam int MAX_WIDTH_DEF = 2048;

  // configuration port
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 1'd1;

  localparam logic [11:0] ROW_WIDTH_RST   = 12'd320;
  localparam logic [3:0]  PLANE_COUNT_RST = 4'd8;

  // group geometry
  localparam int PIX_PER_GROUP = 8;
  localparam int PIX_W         = 8;
  localparam int ENTRY_W       = PIX_PER_GROUP * PIX_W;
  localparam logic [3:0] FULL_COUNT = 4'd8;

  // per-item control from the sequencer to the merge stage
  typedef struct packed {
    logic [2:0] plane;      // bit of each pixel set by this item
    logic       first;      // plane 0: entry is overwritten
    logic       emit;       // last plane: a group is produced
    logic       row_end;    // last byte of the row plane
    logic [3:0] count;      // valid pixels in the group
  } item_cmd_t;

endpackage

// ----- rtl/bpcr_store.sv -----
// ---------------------------------------------------------------------------
// bpcr_store
// Line store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module bpcr_store
  import bpcr_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data (old data on same-cycle write)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/bpcr_seq.sv -----
// ---------------------------------------------------------------------------
// bpcr_seq
// Config registers and the byte position / plane counters of the row.
// ---------------------------------------------------------------------------
module bpcr_seq
  import bpcr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int AW        = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc,
  output logic [AW-1:0]         pos,
  output item_cmd_t             cmd
);

  localparam logic [15:0] MAXW = 16'(MAX_WIDTH);

  logic [11:0]   row_width_r, row_width_nxt;
  logic [3:0]    plane_count_r, plane_count_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [2:0]    plane_r, plane_nxt;

  logic [15:0]   rw_min1;
  logic [15:0]   eff_w;
  logic [15:0]   eff_m1;
  logic [15:0]   last_pos_w;
  logic [AW-1:0] last_pos;
  logic [3:0]    tail_count;
  logic [3:0]    eff_p;
  logic [2:0]    last_plane;
  logic          at_row_end;

  // effective geometry from the registers
  always_comb begin
    rw_min1    = (row_width_r == 12'd0) ? 16'd1 : {4'd0, row_width_r};
    eff_w      = (rw_min1 > MAXW) ? MAXW : rw_min1;
    eff_m1     = eff_w - 16'd1;
    last_pos_w = eff_m1 >> 3;
    last_pos   = last_pos_w[AW-1:0];
    tail_count = {1'b0, eff_m1[2:0]} + 4'd1;
    if (plane_count_r == 4'd0) begin
      eff_p = 4'd1;
    end else if (plane_count_r > 4'd8) begin
      eff_p = 4'd8;
    end else begin
      eff_p = plane_count_r;
    end
    last_plane = 3'(eff_p - 4'd1);
  end

  // control for the item now at the input
  always_comb begin
    at_row_end  = (pos_r == last_pos);
    pos         = pos_r;
    cmd.plane   = plane_r;
    cmd.first   = (plane_r == 3'd0);
    cmd.emit    = (plane_r == last_plane);
    cmd.row_end = at_row_end;
    cmd.count   = at_row_end ? tail_count : FULL_COUNT;
  end

  // counter and register update; a config write restarts the row
  always_comb begin
    row_width_nxt   = row_width_r;
    plane_count_nxt = plane_count_r;
    pos_nxt         = pos_r;
    plane_nxt       = plane_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_WIDTH:   row_width_nxt   = cfg_data;
        REG_PLANE_COUNT: plane_count_nxt = cfg_data[3:0];
        default:         row_width_nxt   = row_width_r;
      endcase
      pos_nxt   = '0;
      plane_nxt = 3'd0;
    end else if (acc) begin
      if (at_row_end) begin
        pos_nxt   = '0;
        plane_nxt = (plane_r == last_plane) ? 3'd0 : plane_r + 3'd1;
      end else begin
        pos_nxt = pos_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= ROW_WIDTH_RST;
      plane_count_r <= PLANE_COUNT_RST;
      pos_r         <= '0;
      plane_r       <= 3'd0;
    end else begin
      row_width_r   <= row_width_nxt;
      plane_count_r <= plane_count_nxt;
      pos_r         <= pos_nxt;
      plane_r       <= plane_nxt;
    end
  end

endmodule

// ----- rtl/bpcr_merge.sv -----
// ---------------------------------------------------------------------------
// bpcr_merge
// Read-modify-write stage: merges a plane byte into its store entry,
// forwards the last write, and holds the output group register.
// ---------------------------------------------------------------------------
module bpcr_merge
  import bpcr_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item capture
  input  logic                          acc,
  input  logic [7:0]                    in_byte,
  input  logic [AW-1:0]                 in_pos,
  input  item_cmd_t                     in_cmd,
  output logic                          take_ok,
  // store
  input  logic [ENTRY_W-1:0]            rd_data,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [ENTRY_W-1:0]            wr_data,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [PIX_PER_GROUP-1:0][7:0] out_pix,
  output logic [3:0]                    out_count,
  output logic                          out_row_end
);

  // stage 1 registers
  logic          s1_v_r, s1_v_nxt;
  item_cmd_t     s1_cmd_r;
  logic [AW-1:0] s1_pos_r;
  logic [7:0]    s1_byte_r;

  // last write, for a read that raced it
  logic               fw_v_r;
  logic [AW-1:0]      fw_addr_r;
  logic [ENTRY_W-1:0] fw_data_r;

  // output group
  logic                          out_v_r, out_v_nxt;
  logic [PIX_PER_GROUP-1:0][7:0] out_pix_r;
  logic [3:0]                    out_count_r;
  logic                          out_row_end_r;

  logic [ENTRY_W-1:0]            base;
  logic [PIX_PER_GROUP-1:0][7:0] merged;
  logic [PIX_PER_GROUP-1:0][7:0] trimmed;
  logic                          s1_go;

  // stage 1 may retire when its group has somewhere to go
  assign s1_go   = s1_v_r && (!s1_cmd_r.emit || !out_v_r || out_ready);
  assign take_ok = !s1_v_r || s1_go;

  // merge the byte into the entry; plane 0 starts from zero
  always_comb begin
    base = (fw_v_r && (fw_addr_r == s1_pos_r)) ? fw_data_r : rd_data;
    for (int k = 0; k < PIX_PER_GROUP; k++) begin
      merged[k] = (s1_cmd_r.first ? 8'd0 : base[PIX_W*k +: PIX_W])
                | ({7'd0, s1_byte_r[PIX_PER_GROUP-1-k]} << s1_cmd_r.plane);
      trimmed[k] = (4'(k) < s1_cmd_r.count) ? merged[k] : 8'd0;
    end
  end

  assign wr_en   = s1_go;
  assign wr_addr = s1_pos_r;
  assign wr_data = merged;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_go && s1_cmd_r.emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fw_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_go) begin
        fw_v_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r  <= in_cmd;
      s1_pos_r  <= in_pos;
      s1_byte_r <= in_byte;
    end
    if (s1_go) begin
      fw_addr_r <= s1_pos_r;
      fw_data_r <= merged;
    end
    if (s1_go && s1_cmd_r.emit) begin
      out_pix_r     <= trimmed;
      out_count_r   <= s1_cmd_r.count;
      out_row_end_r <= s1_cmd_r.row_end;
    end
  end

  assign out_valid   = out_v_r;
  assign out_pix     = out_pix_r;
  assign out_count   = out_count_r;
  assign out_row_end = out_row_end_r;

endmodule

// ----- rtl/bitplane_to_chunky_row.sv -----
// Throughput: one item per cycle while no finished group waits on out_ready, set by
//   the line store's single read port and single write port; a read racing the
//   previous write takes forwarded data. Path: stage-1 register, output register.
// Reset (rst_n low, synchronous): row_width 320, plane_count 8, row restarts,
//   pipeline and output empty. The line store is not cleared; plane 0 writes
//   each entry before it is read.
// ---------------------------------------------------------------------------
// bitplane_to_chunky_row
// Converts interleaved bitplane bytes into groups of up to 8 chunky pixels.
// ---------------------------------------------------------------------------
module bitplane_to_chunky_row
  import bpcr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // bitplane bytes in
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_plane_byte,
  // pixel groups out
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pixel_0,
  output logic [7:0]            out_pixel_1,
  output logic [7:0]            out_pixel_2,
  output logic [7:0]            out_pixel_3,
  output logic [7:0]            out_pixel_4,
  output logic [7:0]            out_pixel_5,
  output logic [7:0]            out_pixel_6,
  output logic [7:0]            out_pixel_7,
  output logic [3:0]            out_pixel_count,
  output logic                  out_row_end
);

  localparam int DEPTH = (MAX_WIDTH + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                          acc;
  logic                          take_ok;
  logic [AW-1:0]                 pos;
  item_cmd_t                     cmd;
  logic [ENTRY_W-1:0]            rd_data;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [ENTRY_W-1:0]            wr_data;
  logic [PIX_PER_GROUP-1:0][7:0] pix;

  assign in_ready = take_ok;
  assign acc      = in_valid && take_ok;

  bpcr_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .pos       (pos),
    .cmd       (cmd)
  );

  bpcr_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (pos),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bpcr_merge #(
    .AW (AW)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_byte     (in_plane_byte),
    .in_pos      (pos),
    .in_cmd      (cmd),
    .take_ok     (take_ok),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pix     (pix),
    .out_count   (out_pixel_count),
    .out_row_end (out_row_end)
  );

  // leftmost pixel first
  assign out_pixel_0 = pix[0];
  assign out_pixel_1 = pix[1];
  assign out_pixel_2 = pix[2];
  assign out_pixel_3 = pix[3];
  assign out_pixel_4 = pix[4];
  assign out_pixel_5 = pix[5];
  assign out_pixel_6 = pix[6];
  assign out_pixel_7 = pix[7];

endmodule

// ----- rtl/bpcr_chk.sv -----
// ---------------------------------------------------------------------------
// bpcr_chk
// Port-level checks of the converter's result channel, bound to the top.
// ---------------------------------------------------------------------------
`include "bitplane_to_chunky_row_assert.svh"

module bpcr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_0,
  input logic [7:0] out_pixel_7,
  input logic [3:0] out_pixel_count,
  input logic       out_row_end
);

  // a stalled item holds
  `BPCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_0) && $stable(out_pixel_count) && $stable(out_row_end))

  // count is always 1..8
  `BPCR_ASSERT_NOW(a_count_range, out_valid, (out_pixel_count != 4'd0) && (out_pixel_count <= 4'd8))

  // a short group only at the right edge of a row
  `BPCR_ASSERT_NOW(a_short_at_edge, out_valid && (out_pixel_count != 4'd8), out_row_end)

  // pixel 7 of a short group, past the edge, reads zero
  `BPCR_ASSERT_NOW(a_trim_zero, out_valid && (out_pixel_count != 4'd8), out_pixel_7 == 8'd0)

endmodule

bind bitplane_to_chunky_row bpcr_chk u_bpcr_chk (.*);
